[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the OSD text write sequencer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that forces a consequence in the cycle after it.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[hw/rtl/otws_pkg.sv]
// ----------------------------------------------------------------------------
// OSD text write sequencer package
// Types, constants and the font translation shared by the sequencer files.
// ----------------------------------------------------------------------------
`default_nettype none

package otws_pkg;

   // Message store geometry. The depth is a power of two.
   localparam int STORE_DEPTH = 256;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);

   typedef logic [STORE_AW-1:0] otws_addr_type;

   localparam logic [8:0] ROW_WIDTH = 9'd30;

   // Command codes.
   localparam logic [2:0] CMD_LOAD_CHAR    = 3'd0;
   localparam logic [2:0] CMD_START_WRITE  = 3'd1;
   localparam logic [2:0] CMD_START_CLEAR  = 3'd2;
   localparam logic [2:0] CMD_START_ENABLE = 3'd3;
   localparam logic [2:0] CMD_BYTE_DONE    = 3'd4;

   // Chip select actions.
   localparam logic [1:0] CS_NONE        = 2'd0;
   localparam logic [1:0] CS_RAISE_LOWER = 2'd1;
   localparam logic [1:0] CS_LOWER       = 2'd2;
   localparam logic [1:0] CS_RAISE_STOP  = 2'd3;

   // Chip register addresses and fixed bytes.
   localparam logic [7:0] REG_VM0      = 8'h00;
   localparam logic [7:0] REG_DMM      = 8'h04;
   localparam logic [7:0] REG_DMAH     = 8'h05;
   localparam logic [7:0] REG_DMAL     = 8'h06;
   localparam logic [7:0] BYTE_AUTOINC = 8'h01;
   localparam logic [7:0] BYTE_END     = 8'hFF;
   localparam logic [7:0] BYTE_CLEAR   = 8'h26;
   localparam logic [7:0] BYTE_ENABLE  = 8'h2C;
   localparam logic [7:0] VIDEO_MODE_RESET = 8'd40;

   // Steps of the text write sequence before the message bytes.
   localparam logic [8:0] STEP_DMAH     = 9'd0;
   localparam logic [8:0] STEP_ADDR_HI  = 9'd1;
   localparam logic [8:0] STEP_DMAL     = 9'd2;
   localparam logic [8:0] STEP_ADDR_LO  = 9'd3;
   localparam logic [8:0] STEP_DMM      = 9'd4;
   localparam logic [8:0] STEP_AUTOINC  = 9'd5;
   localparam logic [8:0] STEP_CHARS    = 9'd6;

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'b001,
      MODE_CLEAR  = 3'b010,
      MODE_ENABLE = 3'b100
   } otws_mode_type;

   // One result word as decided by the sequencer.
   typedef struct packed {
      logic       valid;
      logic       from_store;
      logic [7:0] spi_byte;
      logic       sends_byte;
      logic [1:0] cs_action;
      logic       last;
   } otws_step_type;

   // Message store access as decided in a given cycle.
   typedef struct packed {
      logic          wr_en;
      otws_addr_type wr_addr;
      logic [7:0]    wr_data;
      logic          rd_en;
      otws_addr_type rd_addr;
   } otws_mem_type;

   function automatic logic [7:0] font_code(input logic [7:0] c);
      logic [7:0] code;
      if (c inside {[8'h61:8'h7A]}) begin
         code = c - 8'h3C;
      end else if (c inside {[8'h31:8'h39]}) begin
         code = c - 8'h30;
      end else if (c inside {[8'h41:8'h5A]}) begin
         code = c - 8'h36;
      end else if (c == 8'h20) begin
         code = 8'h00;
      end else if (c == 8'h30) begin
         code = 8'h0A;
      end else if (c == 8'h2E) begin
         code = 8'h41;
      end else begin
         code = 8'h20;
      end
      return code;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/otws_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module otws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/otws_seq.sv]
// ----------------------------------------------------------------------------
// OSD text write sequence control
// Holds the sequence state and decides each result word and store access.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module otws_seq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [2:0]            cmd,
   input  wire logic [7:0]            slot,
   input  wire logic [7:0]            char_code,
   input  wire logic                  translate,
   input  wire logic [3:0]            row,
   input  wire logic [4:0]            col,
   input  wire logic [7:0]            message_length,
   input  wire logic                  csr_wr_en,
   input  wire logic [7:0]            csr_wr_data,
   output otws_pkg::otws_step_type    step,
   output otws_pkg::otws_mem_type     mem
);

   otws_pkg::otws_mode_type mode_ff, mode_in;
   logic       busy_ff, busy_in;
   logic [8:0] step_ff, step_in;
   logic       addr_hi_ff, addr_hi_in;
   logic [7:0] addr_lo_ff, addr_lo_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] vmode_ff, vmode_in;
   logic [8:0] pos;
   logic [8:0] char_end;

   always_comb begin
      mode_in    = mode_ff;
      busy_in    = busy_ff;
      step_in    = step_ff;
      addr_hi_in = addr_hi_ff;
      addr_lo_in = addr_lo_ff;
      len_in     = len_ff;
      vmode_in   = csr_wr_en ? csr_wr_data : vmode_ff;
      pos        = ({5'b0, row} * otws_pkg::ROW_WIDTH) + {4'b0, col};
      char_end   = {1'b0, len_ff} + otws_pkg::STEP_CHARS;
      step       = '0;
      mem        = '0;
      mem.wr_addr = otws_pkg::otws_addr_type'(slot);
      mem.wr_data = translate ? otws_pkg::font_code(char_code) : char_code;
      mem.rd_addr = otws_pkg::otws_addr_type'(step_ff - otws_pkg::STEP_CHARS);
      if (accept) begin
         case (cmd)
            otws_pkg::CMD_LOAD_CHAR: begin
               mem.wr_en = (int'(slot) < otws_pkg::STORE_DEPTH);
            end
            otws_pkg::CMD_START_WRITE: begin
               mode_in    = otws_pkg::MODE_NORMAL;
               busy_in    = 1'b1;
               step_in    = '0;
               addr_hi_in = pos[8];
               addr_lo_in = pos[7:0];
               len_in     = message_length;
               step.valid      = 1'b1;
               step.spi_byte   = otws_pkg::REG_DMAH;
               step.sends_byte = 1'b1;
               step.cs_action  = otws_pkg::CS_LOWER;
            end
            otws_pkg::CMD_START_CLEAR, otws_pkg::CMD_START_ENABLE: begin
               mode_in = (cmd == otws_pkg::CMD_START_CLEAR) ?
                         otws_pkg::MODE_CLEAR : otws_pkg::MODE_ENABLE;
               busy_in = 1'b1;
               step_in = '0;
               step.valid      = 1'b1;
               step.spi_byte   = otws_pkg::REG_VM0;
               step.sends_byte = 1'b1;
               step.cs_action  = otws_pkg::CS_RAISE_LOWER;
            end
            otws_pkg::CMD_BYTE_DONE: begin
               if (busy_ff) begin
                  step.valid      = 1'b1;
                  step.sends_byte = 1'b1;
                  step.cs_action  = otws_pkg::CS_RAISE_LOWER;
                  if (mode_ff != otws_pkg::MODE_NORMAL) begin
                     if (step_ff == otws_pkg::STEP_DMAH) begin
                        step_in        = 9'd1;
                        step.spi_byte  = (mode_ff == otws_pkg::MODE_CLEAR) ?
                                         otws_pkg::BYTE_CLEAR : otws_pkg::BYTE_ENABLE;
                        step.cs_action = otws_pkg::CS_NONE;
                     end else begin
                        mode_in         = otws_pkg::MODE_NORMAL;
                        busy_in         = 1'b0;
                        step_in         = '0;
                        step.sends_byte = 1'b0;
                        step.cs_action  = otws_pkg::CS_RAISE_STOP;
                        step.last       = 1'b1;
                     end
                  end else begin
                     step_in = step_ff + 9'd1;
                     case (step_ff)
                        otws_pkg::STEP_DMAH: begin
                           step.spi_byte = otws_pkg::REG_DMAH;
                        end
                        otws_pkg::STEP_ADDR_HI: begin
                           step.spi_byte  = {7'b0, addr_hi_ff};
                           step.cs_action = otws_pkg::CS_NONE;
                        end
                        otws_pkg::STEP_DMAL: begin
                           step.spi_byte = otws_pkg::REG_DMAL;
                        end
                        otws_pkg::STEP_ADDR_LO: begin
                           step.spi_byte  = addr_lo_ff;
                           step.cs_action = otws_pkg::CS_NONE;
                        end
                        otws_pkg::STEP_DMM: begin
                           step.spi_byte = otws_pkg::REG_DMM;
                        end
                        otws_pkg::STEP_AUTOINC: begin
                           step.spi_byte  = otws_pkg::BYTE_AUTOINC;
                           step.cs_action = otws_pkg::CS_NONE;
                        end
                        default: begin
                           if (step_ff < char_end) begin
                              step.from_store = 1'b1;
                              mem.rd_en       = 1'b1;
                           end else if (step_ff == char_end) begin
                              step.spi_byte = otws_pkg::BYTE_END;
                           end else if (step_ff == char_end + 9'd1) begin
                              step.spi_byte = otws_pkg::REG_VM0;
                           end else if (step_ff == char_end + 9'd2) begin
                              step.spi_byte  = vmode_ff;
                              step.cs_action = otws_pkg::CS_NONE;
                           end else begin
                              busy_in         = 1'b0;
                              step_in         = '0;
                              step.sends_byte = 1'b0;
                              step.cs_action  = otws_pkg::CS_RAISE_STOP;
                              step.last       = 1'b1;
                           end
                        end
                     endcase
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= otws_pkg::MODE_NORMAL;
         busy_ff    <= 1'b0;
         step_ff    <= '0;
         addr_hi_ff <= 1'b0;
         addr_lo_ff <= '0;
         len_ff     <= '0;
         vmode_ff   <= otws_pkg::VIDEO_MODE_RESET;
      end else begin
         mode_ff    <= mode_in;
         busy_ff    <= busy_in;
         step_ff    <= step_in;
         addr_hi_ff <= addr_hi_in;
         addr_lo_ff <= addr_lo_in;
         len_ff     <= len_in;
         vmode_ff   <= vmode_in;
      end
   end

   `ASSERT_ALWAYS(a_idle_step_zero, clock, reset, !busy_ff |-> step_ff == 9'd0, "Step count left non-zero while idle")
   `ASSERT_ALWAYS(a_short_mode_step, clock, reset, mode_ff != otws_pkg::MODE_NORMAL |-> step_ff <= 9'd1, "Clear or enable sequence ran past its second step")
   `ASSERT_ALWAYS(a_read_in_text, clock, reset, mem.rd_en |-> busy_ff && mode_ff == otws_pkg::MODE_NORMAL && !mem.wr_en, "Store read outside a text write")
   `ASSERT_NEXT(a_start_write, clock, reset, accept && cmd == otws_pkg::CMD_START_WRITE, busy_ff && step_ff == 9'd0 && mode_ff == otws_pkg::MODE_NORMAL, "Start write did not restart the sequence")

endmodule

`default_nettype wire

[hw/rtl/osd_text_write_sequencer.sv]
// ----------------------------------------------------------------------------
// OSD text write sequencer
// Turns load, start and byte-done commands into serial bytes for an OSD chip.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Content
//  req_     in         req_tvalid/req_tready  command word
//  rsp_     out        rsp_tvalid/rsp_tready  serial byte with chip select action
//  csr_     in         csr_wr_en              video mode register value
//
//  One command word is accepted per cycle unless the result side stalls; a result word
//  passes the result stage, then the output register. The message store has one
//  read and one write port; the read is registered. Those two registers absorb a
//  stalled result side. Reset is synchronous; the message store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module osd_text_write_sequencer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // slot[7:0], char_code[15:8], row[19:16], col[24:20], message_length[32:25]
   input  wire logic [39:0] req_tdata,
   // cmd[2:0], translate[3]
   input  wire logic [3:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // spi_byte[7:0]
   output logic      [7:0]  rsp_tdata,
   // sends_byte[0], cs_action[2:1]
   output logic      [2:0]  rsp_tuser,
   output logic             rsp_tlast,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data
);

   otws_pkg::otws_step_type step;
   otws_pkg::otws_mem_type  mem;
   otws_pkg::otws_step_type s1_ff, s1_in;
   logic       s1_valid_ff, s1_valid_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_sends_ff, out_sends_in;
   logic [1:0] out_cs_ff, out_cs_in;
   logic       out_last_ff, out_last_in;
   logic [7:0] rd_data;
   logic       s1_move;
   logic       accept;

   assign s1_move    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign accept     = req_tvalid && req_tready;

   otws_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .cmd            (req_tuser[2:0]),
      .slot           (req_tdata[7:0]),
      .char_code      (req_tdata[15:8]),
      .translate      (req_tuser[3]),
      .row            (req_tdata[19:16]),
      .col            (req_tdata[24:20]),
      .message_length (req_tdata[32:25]),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .step           (step),
      .mem            (mem)
   );

   otws_ram #(
      .WIDTH (8),
      .DEPTH (otws_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem.wr_en),
      .wr_addr (mem.wr_addr),
      .wr_data (mem.wr_data),
      .rd_en   (mem.rd_en),
      .rd_addr (mem.rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_in        = s1_ff;
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_sends_in = out_sends_ff;
      out_cs_in    = out_cs_ff;
      out_last_in  = out_last_ff;
      if (accept) begin
         s1_in       = step;
         s1_valid_in = step.valid;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      if (s1_move) begin
         out_valid_in = 1'b1;
         out_byte_in  = s1_ff.from_store ? rd_data : s1_ff.spi_byte;
         out_sends_in = s1_ff.sends_byte;
         out_cs_in    = s1_ff.cs_action;
         out_last_in  = s1_ff.last;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s1_ff        <= s1_in;
      out_byte_ff  <= out_byte_in;
      out_sends_ff <= out_sends_in;
      out_cs_ff    <= out_cs_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = {out_cs_ff, out_sends_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// OSD text write sequencer testbench
// Sends command words to the sequencer and checks every serial byte word that
// comes back against a behavioural copy in the bench or a fixed directed word.
// A short table of directed words comes first, followed by random phases.
// Each phase starts with a new video mode value written once all expected words
// have come back. Both channels are throttled at random.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_WORDS  = 650;
   localparam int PHASES        = 5;

   localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic [7:0] spi_byte;
      logic       sends_byte;
      logic [1:0] cs_action;
      logic       last;
   } osd_byte_type;

   typedef struct packed {
      logic [2:0]   cmd;
      logic         translate;
      logic [7:0]   slot;
      logic [7:0]   char_code;
      logic [3:0]   row;
      logic [4:0]   col;
      logic [7:0]   msg_len;
      logic         fixed;
      osd_byte_type want;
   } cmd_row_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata   = '0;
   logic [3:0]  req_tuser   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wr_en   = 1'b0;
   logic [7:0]  csr_wr_data = '0;

   otws_pkg::otws_mode_type seq_mode = otws_pkg::MODE_NORMAL;
   bit            seq_busy   = 1'b0;
   logic [8:0]    step_no    = '0;
   logic          addr_hi    = 1'b0;
   logic [7:0]    addr_lo    = '0;
   logic [7:0]    text_len   = '0;
   logic [7:0]    video_mode = otws_pkg::VIDEO_MODE_RESET;
   logic [7:0]    char_mem [256];
   bit            char_written [256];

   osd_byte_type expected_bytes [$];
   cmd_row_type  directed_rows [$];
   int        error_count = 0;
   int        cycle_count = 0;
   int        word_count  = 0;
   bit        send_steady = 1'b0;
   bit        take_steady = 1'b0;

   osd_text_write_sequencer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] to_font(input logic [7:0] c);
      if (c >= 8'h61 && c <= 8'h7A) return c - 8'h3C;
      if (c >= 8'h31 && c <= 8'h39) return c - 8'h30;
      if (c >= 8'h41 && c <= 8'h5A) return c - 8'h36;
      if (c == 8'h20) return 8'h00;
      if (c == 8'h30) return 8'h0A;
      if (c == 8'h2E) return 8'h41;
      return 8'h20;
   endfunction

   function automatic cmd_row_type row_of(input logic [2:0] cmd, input logic tr,
                                          input logic [7:0] slot, input logic [7:0] ch,
                                          input logic [3:0] row, input logic [4:0] col,
                                          input logic [7:0] len, input logic fixed,
                                          input osd_byte_type want);
      cmd_row_type w;
      w.cmd       = cmd;
      w.translate = tr;
      w.slot      = slot;
      w.char_code = ch;
      w.row       = row;
      w.col       = col;
      w.msg_len   = len;
      w.fixed     = fixed;
      w.want      = want;
      return w;
   endfunction

   function automatic void predict_osd_byte(input cmd_row_type w, output bit produced,
                                            output osd_byte_type r);
      logic [8:0] addr;
      logic [8:0] k;
      logic [8:0] n;
      logic [8:0] idx;
      produced = 1'b1;
      r = '0;
      case (w.cmd)
         otws_pkg::CMD_LOAD_CHAR: begin
            char_mem[w.slot] = w.translate ? to_font(w.char_code) : w.char_code;
            char_written[w.slot] = 1'b1;
            produced = 1'b0;
         end
         otws_pkg::CMD_START_WRITE: begin
            addr = w.row * otws_pkg::ROW_WIDTH + w.col;
            seq_mode = otws_pkg::MODE_NORMAL;
            seq_busy = 1'b1;
            step_no = '0;
            addr_hi = addr[8];
            addr_lo = addr[7:0];
            text_len = w.msg_len;
            r = {otws_pkg::REG_DMAH, 1'b1, otws_pkg::CS_LOWER, 1'b0};
         end
         otws_pkg::CMD_START_CLEAR, otws_pkg::CMD_START_ENABLE: begin
            seq_mode = (w.cmd == otws_pkg::CMD_START_CLEAR) ?
                       otws_pkg::MODE_CLEAR : otws_pkg::MODE_ENABLE;
            seq_busy = 1'b1;
            step_no = '0;
            r = {otws_pkg::REG_VM0, 1'b1, otws_pkg::CS_RAISE_LOWER, 1'b0};
         end
         otws_pkg::CMD_BYTE_DONE: begin
            if (!seq_busy) begin
               produced = 1'b0;
            end else if (seq_mode != otws_pkg::MODE_NORMAL) begin
               if (step_no == 9'd0) begin
                  step_no = 9'd1;
                  r = {(seq_mode == otws_pkg::MODE_CLEAR) ?
                       otws_pkg::BYTE_CLEAR : otws_pkg::BYTE_ENABLE,
                       1'b1, otws_pkg::CS_NONE, 1'b0};
               end else begin
                  seq_mode = otws_pkg::MODE_NORMAL;
                  seq_busy = 1'b0;
                  step_no = '0;
                  r = {8'h00, 1'b0, otws_pkg::CS_RAISE_STOP, 1'b1};
               end
            end else begin
               k = step_no;
               n = {1'b0, text_len};
               step_no = k + 9'd1;
               case (k)
                  otws_pkg::STEP_DMAH:
                     r = {otws_pkg::REG_DMAH, 1'b1, otws_pkg::CS_RAISE_LOWER, 1'b0};
                  otws_pkg::STEP_ADDR_HI:
                     r = {7'd0, addr_hi, 1'b1, otws_pkg::CS_NONE, 1'b0};
                  otws_pkg::STEP_DMAL:
                     r = {otws_pkg::REG_DMAL, 1'b1, otws_pkg::CS_RAISE_LOWER, 1'b0};
                  otws_pkg::STEP_ADDR_LO:
                     r = {addr_lo, 1'b1, otws_pkg::CS_NONE, 1'b0};
                  otws_pkg::STEP_DMM:
                     r = {otws_pkg::REG_DMM, 1'b1, otws_pkg::CS_RAISE_LOWER, 1'b0};
                  otws_pkg::STEP_AUTOINC:
                     r = {otws_pkg::BYTE_AUTOINC, 1'b1, otws_pkg::CS_NONE, 1'b0};
                  default: begin
                     idx = k - otws_pkg::STEP_CHARS;
                     if (k < otws_pkg::STEP_CHARS + n) begin
                        r = {char_mem[idx[7:0]], 1'b1, otws_pkg::CS_RAISE_LOWER, 1'b0};
                     end else if (k == otws_pkg::STEP_CHARS + n) begin
                        r = {otws_pkg::BYTE_END, 1'b1, otws_pkg::CS_RAISE_LOWER, 1'b0};
                     end else if (k == otws_pkg::STEP_CHARS + n + 9'd1) begin
                        r = {otws_pkg::REG_VM0, 1'b1, otws_pkg::CS_RAISE_LOWER, 1'b0};
                     end else if (k == otws_pkg::STEP_CHARS + n + 9'd2) begin
                        r = {video_mode, 1'b1, otws_pkg::CS_NONE, 1'b0};
                     end else begin
                        seq_busy = 1'b0;
                        step_no = '0;
                        r = {8'h00, 1'b0, otws_pkg::CS_RAISE_STOP, 1'b1};
                     end
                  end
               endcase
            end
         end
         default: produced = 1'b0;
      endcase
   endfunction

   task automatic send_word(input cmd_row_type w);
      int           gap;
      bit           produced;
      osd_byte_type r;
      if ($urandom_range(0, 19) == 0) send_steady = !send_steady;
      gap = send_steady ? 0 : int'($urandom_range(0, 19));
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, w.msg_len, w.col, w.row, w.char_code, w.slot};
      req_tuser  <= {w.translate, w.cmd};
      do @(posedge clock); while (!req_tready);
      predict_osd_byte(w, produced, r);
      if (w.fixed) begin
         expected_bytes.push_back(w.want);
      end else if (produced) begin
         expected_bytes.push_back(r);
      end
      word_count++;
   endtask

   task automatic random_word();
      cmd_row_type w;
      int          pick;
      logic [8:0]  idx;
      w = '0;
      w.slot      = 8'($urandom);
      w.char_code = 8'($urandom);
      w.translate = 1'($urandom);
      w.row       = 4'($urandom);
      w.col       = 5'($urandom);
      w.msg_len   = 8'($urandom);
      if ($urandom_range(0, 99) < 60) w.char_code = 8'($urandom_range(8'h20, 8'h7A));
      pick = int'($urandom_range(0, 99));
      if (seq_busy) begin
         if (pick < 88) w.cmd = otws_pkg::CMD_BYTE_DONE;
         else if (pick < 94) w.cmd = otws_pkg::CMD_LOAD_CHAR;
         else if (pick < 98) w.cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
         else if (pick < 99) w.cmd = otws_pkg::CMD_START_WRITE;
         else w.cmd = 3'($urandom_range(otws_pkg::CMD_START_CLEAR,
                                        otws_pkg::CMD_START_ENABLE));
      end else begin
         if (pick < 30) w.cmd = otws_pkg::CMD_LOAD_CHAR;
         else if (pick < 60) w.cmd = otws_pkg::CMD_START_WRITE;
         else if (pick < 75) w.cmd = 3'($urandom_range(otws_pkg::CMD_START_CLEAR,
                                                       otws_pkg::CMD_START_ENABLE));
         else if (pick < 88) w.cmd = otws_pkg::CMD_BYTE_DONE;
         else w.cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
      end
      if (w.cmd == otws_pkg::CMD_LOAD_CHAR && $urandom_range(0, 1) == 1)
         w.slot = 8'($urandom_range(0, 31));
      pick = int'($urandom_range(0, 99));
      if (w.cmd == otws_pkg::CMD_START_WRITE && pick < 85)
         w.msg_len = 8'($urandom_range(0, 12));
      else if (w.cmd == otws_pkg::CMD_START_WRITE && pick < 97)
         w.msg_len = 8'($urandom_range(0, 48));
      // A byte-done that would send a character never loaded loads it first.
      idx = step_no - otws_pkg::STEP_CHARS;
      if (w.cmd == otws_pkg::CMD_BYTE_DONE && seq_busy && seq_mode == otws_pkg::MODE_NORMAL &&
          step_no >= otws_pkg::STEP_CHARS &&
          step_no < otws_pkg::STEP_CHARS + {1'b0, text_len} &&
          !char_written[idx[7:0]]) begin
         w.cmd  = otws_pkg::CMD_LOAD_CHAR;
         w.slot = idx[7:0];
      end
      send_word(w);
   endtask

   task automatic drain_words();
      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin
      int           gap;
      osd_byte_type got;
      osd_byte_type want;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 19) == 0) take_steady = !take_steady;
         gap = take_steady ? 0 : int'($urandom_range(0, 19));
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got = {rsp_tdata, rsp_tuser[0], rsp_tuser[2:1], rsp_tlast};
         if (expected_bytes.size() == 0) begin
            $error("unexpected word: spi_byte %0h, tuser %0h, tlast %0b",
                   rsp_tdata, rsp_tuser, rsp_tlast);
            error_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (got.spi_byte !== want.spi_byte) begin
               $error("spi_byte: expected %0h, got %0h", want.spi_byte, got.spi_byte);
               error_count++;
            end
            if (got.sends_byte !== want.sends_byte) begin
               $error("sends_byte: expected %0h, got %0h", want.sends_byte, got.sends_byte);
               error_count++;
            end
            if (got.cs_action !== want.cs_action) begin
               $error("cs_action: expected %0h, got %0h", want.cs_action, got.cs_action);
               error_count++;
            end
            if (got.last !== want.last) begin
               $error("last: expected %0h, got %0h", want.last, got.last);
               error_count++;
            end
         end
      end
   end

   initial begin
      // Row 15, column 29 gives address 479: high bit set, low byte 0xDF.
      directed_rows.push_back(row_of(otws_pkg::CMD_BYTE_DONE, 1'b0, 8'h00, 8'h00,
                                     4'd0, 5'd0, 8'd0, 1'b0, '0));
      directed_rows.push_back(row_of(CMD_SPARE_LAST, 1'b1, 8'hFF, 8'hFF,
                                     4'd15, 5'd31, 8'd255, 1'b0, '0));
      directed_rows.push_back(row_of(otws_pkg::CMD_LOAD_CHAR, 1'b1, 8'h00, 8'h61,
                                     4'd0, 5'd0, 8'd0, 1'b0, '0));
      directed_rows.push_back(row_of(otws_pkg::CMD_LOAD_CHAR, 1'b1, 8'h01, 8'h2E,
                                     4'd0, 5'd0, 8'd0, 1'b0, '0));
      directed_rows.push_back(row_of(otws_pkg::CMD_LOAD_CHAR, 1'b0, 8'hFF, 8'hFF,
                                     4'd0, 5'd0, 8'd0, 1'b0, '0));
      directed_rows.push_back(row_of(otws_pkg::CMD_START_WRITE, 1'b0, 8'h00, 8'h00,
                                     4'd15, 5'd29, 8'd2, 1'b1,
                                     {otws_pkg::REG_DMAH, 1'b1, otws_pkg::CS_LOWER, 1'b0}));
      directed_rows.push_back(row_of(otws_pkg::CMD_BYTE_DONE, 1'b0, 8'h00, 8'h00,
                                     4'd0, 5'd0, 8'd0, 1'b1,
                                     {otws_pkg::REG_DMAH, 1'b1, otws_pkg::CS_RAISE_LOWER,
                                      1'b0}));
      directed_rows.push_back(row_of(otws_pkg::CMD_BYTE_DONE, 1'b0, 8'h00, 8'h00,
                                     4'd0, 5'd0, 8'd0, 1'b1,
                                     {8'h01, 1'b1, otws_pkg::CS_NONE, 1'b0}));
      directed_rows.push_back(row_of(otws_pkg::CMD_BYTE_DONE, 1'b0, 8'h00, 8'h00,
                                     4'd0, 5'd0, 8'd0, 1'b1,
                                     {otws_pkg::REG_DMAL, 1'b1, otws_pkg::CS_RAISE_LOWER,
                                      1'b0}));
      directed_rows.push_back(row_of(otws_pkg::CMD_BYTE_DONE, 1'b0, 8'h00, 8'h00,
                                     4'd0, 5'd0, 8'd0, 1'b1,
                                     {8'hDF, 1'b1, otws_pkg::CS_NONE, 1'b0}));
      directed_rows.push_back(row_of(otws_pkg::CMD_BYTE_DONE, 1'b0, 8'h00, 8'h00,
                                     4'd0, 5'd0, 8'd0, 1'b1,
                                     {otws_pkg::REG_DMM, 1'b1, otws_pkg::CS_RAISE_LOWER,
                                      1'b0}));
      directed_rows.push_back(row_of(otws_pkg::CMD_BYTE_DONE, 1'b0, 8'h00, 8'h00,
                                     4'd0, 5'd0, 8'd0, 1'b1,
                                     {otws_pkg::BYTE_AUTOINC, 1'b1, otws_pkg::CS_NONE,
                                      1'b0}));
      directed_rows.push_back(row_of(otws_pkg::CMD_BYTE_DONE, 1'b0, 8'h00, 8'h00,
                                     4'd0, 5'd0, 8'd0, 1'b0, '0));
      directed_rows.push_back(row_of(otws_pkg::CMD_BYTE_DONE, 1'b0, 8'h00, 8'h00,
                                     4'd0, 5'd0, 8'd0, 1'b0, '0));
      directed_rows.push_back(row_of(otws_pkg::CMD_BYTE_DONE, 1'b0, 8'h00, 8'h00,
                                     4'd0, 5'd0, 8'd0, 1'b1,
                                     {otws_pkg::BYTE_END, 1'b1, otws_pkg::CS_RAISE_LOWER,
                                      1'b0}));
      directed_rows.push_back(row_of(otws_pkg::CMD_BYTE_DONE, 1'b0, 8'h00, 8'h00,
                                     4'd0, 5'd0, 8'd0, 1'b1,
                                     {otws_pkg::REG_VM0, 1'b1, otws_pkg::CS_RAISE_LOWER,
                                      1'b0}));
      directed_rows.push_back(row_of(otws_pkg::CMD_BYTE_DONE, 1'b0, 8'h00, 8'h00,
                                     4'd0, 5'd0, 8'd0, 1'b1,
                                     {otws_pkg::VIDEO_MODE_RESET, 1'b1, otws_pkg::CS_NONE,
                                      1'b0}));
      directed_rows.push_back(row_of(otws_pkg::CMD_BYTE_DONE, 1'b0, 8'h00, 8'h00,
                                     4'd0, 5'd0, 8'd0, 1'b1,
                                     {8'h00, 1'b0, otws_pkg::CS_RAISE_STOP, 1'b1}));
      directed_rows.push_back(row_of(otws_pkg::CMD_START_CLEAR, 1'b0, 8'h00, 8'h00,
                                     4'd0, 5'd0, 8'd0, 1'b1,
                                     {otws_pkg::REG_VM0, 1'b1, otws_pkg::CS_RAISE_LOWER,
                                      1'b0}));
      directed_rows.push_back(row_of(otws_pkg::CMD_BYTE_DONE, 1'b0, 8'h00, 8'h00,
                                     4'd0, 5'd0, 8'd0, 1'b1,
                                     {otws_pkg::BYTE_CLEAR, 1'b1, otws_pkg::CS_NONE, 1'b0}));
      directed_rows.push_back(row_of(otws_pkg::CMD_START_ENABLE, 1'b0, 8'h00, 8'h00,
                                     4'd0, 5'd0, 8'd0, 1'b1,
                                     {otws_pkg::REG_VM0, 1'b1, otws_pkg::CS_RAISE_LOWER,
                                      1'b0}));
      directed_rows.push_back(row_of(otws_pkg::CMD_BYTE_DONE, 1'b0, 8'h00, 8'h00,
                                     4'd0, 5'd0, 8'd0, 1'b1,
                                     {otws_pkg::BYTE_ENABLE, 1'b1, otws_pkg::CS_NONE, 1'b0}));
      directed_rows.push_back(row_of(otws_pkg::CMD_BYTE_DONE, 1'b0, 8'h00, 8'h00,
                                     4'd0, 5'd0, 8'd0, 1'b1,
                                     {8'h00, 1'b0, otws_pkg::CS_RAISE_STOP, 1'b1}));
      directed_rows.push_back(row_of(otws_pkg::CMD_START_WRITE, 1'b0, 8'h00, 8'h00,
                                     4'd0, 5'd31, 8'd255, 1'b1,
                                     {otws_pkg::REG_DMAH, 1'b1, otws_pkg::CS_LOWER, 1'b0}));
      directed_rows.push_back(row_of(otws_pkg::CMD_START_WRITE, 1'b0, 8'h00, 8'h00,
                                     4'd0, 5'd0, 8'd0, 1'b1,
                                     {otws_pkg::REG_DMAH, 1'b1, otws_pkg::CS_LOWER, 1'b0}));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_word(directed_rows[i]);

      word_count = 0;
      for (int p = 0; p < PHASES; p++) begin
         drain_words();
         csr_wr_en   <= 1'b1;
         csr_wr_data <= (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom);
         @(posedge clock);
         video_mode = csr_wr_data;
         csr_wr_en <= 1'b0;
         while (word_count < (p + 1) * RANDOM_WORDS / PHASES) random_word();
      end
      drain_words();

      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
